// ===== rtl/ps2_mouse_packet_tracker_assert.svh =====
// Assertion macros for the PS/2 mouse packet tracker.
// Expects signals named clk and rst in the scope where they are used.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PMPT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmpt: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PMPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmpt: next-cycle check failed");

`endif

// ===== rtl/pmpt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies.
`default_nettype none

package pmpt_pkg;

  // Position of the sync bit in the flags byte
  localparam int unsigned SYNC_BIT = 3;

  // Cursor footprint subtracted from the screen size
  localparam logic [4:0] SPRITE_W = 5'd11;
  localparam logic [4:0] SPRITE_H = 5'd16;

  // Reset positions: center of the default screen
  localparam logic [15:0] CURSOR_X_RESET = 16'd512;
  localparam logic [15:0] CURSOR_Y_RESET = 16'd384;

  // Register reset values
  localparam logic [13:0] SCREEN_W_RESET = 14'd1024;
  localparam logic [13:0] SCREEN_H_RESET = 14'd768;

  // Register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CLAMP_ENABLE  = 2'd2;

  // Byte phase codes; code 3 is treated as the flags phase
  localparam logic [1:0] PHASE_FLAGS = 2'd0;
  localparam logic [1:0] PHASE_DX    = 2'd1;
  localparam logic [1:0] PHASE_DY    = 2'd2;

  // One complete packet as it travels through the queue
  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Live configuration
  typedef struct packed {
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic        clamp_enable;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pmpt_front.sv =====
// Front end: takes mouse bytes, keeps packet sync, pushes full packets.
// Depends on pmpt_pkg.
`default_nettype none

module pmpt_front
  import pmpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire queue_stat_t q_stat,
  output logic             push,
  output packet_t          push_pkt
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] flags_byte;
  logic [7:0] delta_x_byte;
  logic       accept;

  // Only the last byte of a packet needs queue space
  assign in_ready = (phase != PHASE_DY) || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (phase == PHASE_DY);

  assign push_pkt.buttons = flags_byte[2:0];
  assign push_pkt.dx      = delta_x_byte;
  assign push_pkt.dy      = rx_byte;

  // Phase sequencing; a first byte without the sync bit is dropped
  always_comb begin
    unique case (phase)
      PHASE_DX: phase_next = PHASE_DY;
      PHASE_DY: phase_next = PHASE_FLAGS;
      default:  phase_next = rx_byte[SYNC_BIT] ? PHASE_DX : PHASE_FLAGS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_FLAGS;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Byte capture
  always_ff @(posedge clk) begin
    if (accept && (phase == PHASE_DX)) begin
      delta_x_byte <= rx_byte;
    end
    if (accept && (phase != PHASE_DX) && (phase != PHASE_DY) && rx_byte[SYNC_BIT]) begin
      flags_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmpt_queue.sv =====
// Short packet queue between the front end and the position back end.
// Depends on pmpt_pkg.
`default_nettype none

module pmpt_queue
  import pmpt_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire packet_t push_pkt,
  input  wire logic    pop,
  output packet_t      head,
  output queue_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  packet_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmpt_back.sv =====
// Back end: applies packet deltas to the cursor, clamps, holds the result.
// Depends on pmpt_pkg.
`default_nettype none

module pmpt_back
  import pmpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire queue_stat_t q_stat,
  input  wire packet_t     head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic [2:0]       buttons
);

  logic signed [17:0] x_sum;
  logic signed [17:0] y_sum;
  logic [15:0]        x_next;
  logic [15:0]        y_next;

  // Clamp to [0, hi]; hi is screen minus cursor when clamping, else 65535
  function automatic logic [15:0] limit_pos(logic signed [17:0] p, logic [13:0] screen,
                                            logic [4:0] cur, logic clamp);
    logic signed [17:0] hi;
    logic [15:0]        res;
    hi = clamp ? ($signed({4'b0, screen}) - $signed({13'b0, cur})) : 18'sd65535;
    if (hi < 0 || p < 0) begin
      res = '0;
    end else if (p > hi) begin
      res = hi[15:0];
    end else begin
      res = p[15:0];
    end
    return res;
  endfunction

  // Take a packet when the output register is free or being drained
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  // X adds dx, Y subtracts dy (screen Y grows downward)
  assign x_sum  = $signed({2'b00, pos_x}) + $signed({{10{head.dx[7]}}, head.dx});
  assign y_sum  = $signed({2'b00, pos_y}) - $signed({{10{head.dy[7]}}, head.dy});
  assign x_next = limit_pos(x_sum, cfg.screen_width, SPRITE_W, cfg.clamp_enable);
  assign y_next = limit_pos(y_sum, cfg.screen_height, SPRITE_H, cfg.clamp_enable);

  // Cursor position doubles as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= CURSOR_X_RESET;
      pos_y     <= CURSOR_Y_RESET;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        pos_x     <= x_next;
        pos_y     <= y_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buttons <= head.buttons;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// PS/2 mouse packet tracker: one byte per cycle in, one position word per packet out.
// Each word goes through the queue and then the output register after its third byte.
// A full queue stalls a third byte; else the queue decouples intake from output stalls.
// Reset: byte phase to flags, cursor to 512/384, screen 1024x768, clamp on, queue empty.
// Depends on pmpt_pkg, pmpt_front, pmpt_queue, pmpt_back and the assertion header.
`default_nettype none

module ps2_mouse_packet_tracker
  import pmpt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic [2:0]       buttons
);

  cfg_t        cfg;
  queue_stat_t q_stat;
  packet_t     push_pkt;
  packet_t     head;
  logic        push;
  logic        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_W_RESET;
      cfg.screen_height <= SCREEN_H_RESET;
      cfg.clamp_enable  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_CLAMP_ENABLE:  cfg.clamp_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pmpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_pkt (push_pkt)
  );

  pmpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  pmpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .buttons   (buttons)
  );

  // Checks
  `include "ps2_mouse_packet_tracker_assert.svh"

  `PMPT_ASSERT_IMPLY(a_push_has_room, push, !q_stat.full)
  `PMPT_ASSERT_IMPLY(a_pop_has_data, pop, !q_stat.empty)
  `PMPT_ASSERT_NEXT(a_pop_loads_output, pop, out_valid)
  `PMPT_ASSERT_NEXT(a_pop_buttons, pop, buttons == $past(head.buttons))

endmodule

`default_nettype wire

// ===== tb/ps2_mouse_packet_tracker_tb.sv =====
// Self-checking bench for the PS/2 mouse packet tracker: byte stream in, cursor words out.
// A scoreboard class predicts each position word; tasks drive bytes and register writes.
// Depends on pmpt_pkg and the ps2_mouse_packet_tracker RTL.
module ps2_mouse_packet_tracker_tb;
  import pmpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it; writes there are ignored
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam logic [7:0] SYNC_MASK = 8'h01 << SYNC_BIT;

  typedef enum int {MOVE_ANY, MOVE_GROW, MOVE_SHRINK} move_style_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  btn;
  } cursor_word_t;

  // Tracks the cursor from accepted bytes and checks each position word
  class cursor_track;
    logic [13:0] scr_w, scr_h;
    logic        clamp_on;
    logic [1:0]  phase;
    logic [7:0]  flags, dx_byte;
    logic [15:0] cur_x, cur_y;
    cursor_word_t expected_positions[$];
    int mismatches;
    int checked;

    function new();
      scr_w = SCREEN_W_RESET;
      scr_h = SCREEN_H_RESET;
      clamp_on = 1'b1;
      phase = PHASE_FLAGS;
      flags = '0;
      dx_byte = '0;
      cur_x = CURSOR_X_RESET;
      cur_y = CURSOR_Y_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [13:0] v);
      case (idx)
        REG_SCREEN_WIDTH: scr_w = v;
        REG_SCREEN_HEIGHT: scr_h = v;
        REG_CLAMP_ENABLE: clamp_on = v[0];
        default: ;
      endcase
    endfunction

    // Floor at zero; ceiling at 65535, or screen minus cursor when clamping and that is lower
    function logic [15:0] bound(int p, logic [13:0] screen, logic [4:0] cursor);
      int hi;
      hi = 65535;
      if (clamp_on && (int'(screen) - int'(cursor) < hi)) hi = int'(screen) - int'(cursor);
      if (p > hi) p = hi;
      if (p < 0) p = 0;
      return p[15:0];
    endfunction

    function void take_byte(logic [7:0] b);
      int nx, ny;
      case (phase)
        PHASE_DX: begin
          dx_byte = b;
          phase = PHASE_DY;
        end
        PHASE_DY: begin
          nx = int'(cur_x) + int'($signed(dx_byte));
          ny = int'(cur_y) - int'($signed(b));
          phase = PHASE_FLAGS;
          cur_x = bound(nx, scr_w, SPRITE_W);
          cur_y = bound(ny, scr_h, SPRITE_H);
          expected_positions.push_back('{x: cur_x, y: cur_y, btn: flags[2:0]});
        end
        default: begin
          // flags phase: a byte without the sync bit is dropped
          if ((b & SYNC_MASK) != 0) begin
            flags = b;
            phase = PHASE_DX;
          end else begin
            phase = PHASE_FLAGS;
          end
        end
      endcase
    endfunction

    function void check_position(logic [15:0] x, logic [15:0] y, logic [2:0] btn);
      cursor_word_t want;
      checked++;
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word x=%0d y=%0d buttons=%0d", x, y, btn);
        return;
      end
      want = expected_positions.pop_front();
      if (x !== want.x || y !== want.y || btn !== want.btn) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d expected x=%0d y=%0d buttons=%0d, got x=%0d y=%0d buttons=%0d",
                   checked, want.x, want.y, want.btn, x, y, btn);
      end
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pos_x, pos_y;
  logic [2:0]  buttons;

  cursor_track tracker;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int bytes_taken = 0;
  int reg_writes = 0;

  always #4 clk = ~clk;

  ps2_mouse_packet_tracker DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .buttons(buttons)
  );

  // Handshake monitor: sample both channels at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_position(pos_x, pos_y, buttons);
      if (in_valid && in_ready) begin
        tracker.take_byte(rx_byte);
        bytes_taken++;
      end
    end
  end

  // Receiver: random stall before each word, none during bursts
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = out_burst ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one byte after a random gap; returns at the edge that takes it
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One packet, sometimes preceded by a stray byte
  task automatic send_packet(move_style_t style);
    logic [7:0] f, dx, dy;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) send_byte(8'($urandom_range(0, 255)) & ~SYNC_MASK);
    else if (r < 12) send_byte(8'($urandom_range(0, 255)));
    f = 8'($urandom_range(0, 255)) | SYNC_MASK;
    case (style)
      MOVE_GROW: begin
        dx = 8'($urandom_range(8'h70, 8'h7F));
        dy = 8'($urandom_range(8'h80, 8'h8F));
      end
      MOVE_SHRINK: begin
        dx = 8'($urandom_range(8'h80, 8'h8F));
        dy = 8'($urandom_range(8'h70, 8'h7F));
      end
      default: begin
        dx = 8'($urandom_range(0, 255));
        dy = 8'($urandom_range(0, 255));
      end
    endcase
    send_byte(f);
    send_byte(dx);
    send_byte(dy);
  endtask

  task automatic run_packets(int n, move_style_t style);
    in_burst = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    repeat (n) send_packet(style);
  endtask

  // Stop offering bytes and let every expected word come out
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (tracker.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
    reg_writes++;
  endtask

  task automatic set_screen(logic [13:0] w, logic [13:0] h, logic clamp);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    // upper data bits are don't-care for the enable
    write_reg(REG_CLAMP_ENABLE, {13'($urandom_range(0, 8191)), clamp});
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening[$];
    int guard, fails;
    opening = '{8'h00, 8'hF7, 8'h08, 8'h7F, 8'h80, 8'h0F, 8'h80, 8'h7F,
                8'hFF, 8'h00, 8'h00, 8'h0D, 8'hFF, 8'h01, 8'h08, 8'h08,
                8'h08, 8'h1A, 8'h01, 8'hFE};
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: dropped bytes, extreme deltas, all buttons, sync bit as data
    in_burst = ($urandom_range(0, 1) == 0);
    foreach (opening[i]) send_byte(opening[i]);
    settle();

    run_packets(30, MOVE_ANY);
    settle();

    // Screen exactly the cursor size: both limits zero
    set_screen(14'd11, 14'd16, 1'b1);
    run_packets(10, MOVE_ANY);
    settle();

    // Screen smaller than the cursor: limits negative, position pinned at zero
    set_screen(14'd3, 14'd0, 1'b1);
    run_packets(10, MOVE_ANY);
    settle();

    // Largest screen, then push to its edges
    set_screen(14'h3FFF, 14'h3FFF, 1'b1);
    run_packets(10, MOVE_ANY);
    run_packets(140, MOVE_GROW);
    settle();

    // Clamp off: drift until both positions saturate at the top
    write_reg(REG_NONE, 14'h3FFF);
    set_screen(14'h3FFF, 14'h3FFF, 1'b0);
    guard = 0;
    in_burst = 1'b0;
    while ((tracker.cur_x != 16'hFFFF || tracker.cur_y != 16'hFFFF) && guard < 900) begin
      send_packet(MOVE_GROW);
      guard++;
    end
    run_packets(5, MOVE_GROW);
    settle();

    // Clamp back on with a smaller screen: position beyond limit is pulled in
    set_screen(14'd8192, 14'd8192, 1'b1);
    run_packets(10, MOVE_ANY);
    settle();
    set_screen(14'd1024, 14'd768, 1'b1);
    run_packets(20, MOVE_SHRINK);
    settle();

    // Clamp off near the origin: saturate at zero
    set_screen(14'd1024, 14'd768, 1'b0);
    run_packets(10, MOVE_SHRINK);
    run_packets(10, MOVE_ANY);
    settle();

    // Random settings
    repeat (4) begin
      set_screen(($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 40))
                                              : 14'($urandom_range(0, 16383)),
                 ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 40))
                                              : 14'($urandom_range(0, 16383)),
                 1'($urandom_range(0, 1)));
      run_packets(15, MOVE_ANY);
      settle();
    end

    repeat (8) @(posedge clk);
    fails = tracker.mismatches + tracker.pending();
    if (tracker.pending() != 0)
      $display("ERROR: %0d position words never arrived", tracker.pending());
    if (tracker.mismatches > 10)
      $display("%0d mismatches in total", tracker.mismatches);
    $display("Run: %0d bytes taken, %0d position words checked, %0d register writes",
             bytes_taken, tracker.checked, reg_writes);
    $display("Screens from below cursor size to 16383, clamp on and off, saturation at both ends");
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
